/* rtl/mrs_pkg.sv */
// Shared types and constants for the mini RISC-V instruction stepper.
`timescale 1ns / 1ps

package mrs_pkg;

   // Memory map
   localparam logic [31:0] MEM_BASE     = 32'h8000_0000;
   localparam int          MEM_BYTES_DEF = 262144;

   // Request operations
   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_STEP = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   // Major opcodes
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_OP_IMM = 7'h13;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_BRANCH = 7'h63;

   // funct3, funct7 and immediate codes
   localparam logic [2:0] F3_ZERO   = 3'b000;
   localparam logic [2:0] F3_WORD   = 3'b010;
   localparam logic [2:0] F3_BYTE_U = 3'b100;
   localparam logic [6:0] F7_ZERO   = 7'b000_0000;
   localparam logic [11:0] IMM_EBREAK = 12'd1;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] mem_addr;
      logic [31:0] mem_data;
      logic [4:0]  reg_index;
   } mrs_req_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic [31:0] executed_inst;
      logic        halt_flag;
      logic [31:0] reg_value;
   } mrs_rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_EXEC,
      ST_LOAD_WB,
      ST_READ
   } mrs_state_type;

endpackage

/* rtl/mini_riscv_instruction_stepper.sv */
// Top level of the mini RISC-V instruction stepper: banked byte memory, register file, sequencer.
`timescale 1ns / 1ps

// A command is taken when start is high and busy is low; every command gives exactly one
// result beat on rsp_item, marked by rsp_strobe for one cycle, and the receiver cannot stall
// it. After reset the block first clears its memory, one row of four bytes per cycle, and
// busy stays high until every row is cleared. A memory load or an unknown op gives its result
// the cycle after acceptance and the next command can be taken in that same cycle; a register
// read passes through ST_READ; an instruction step goes through fetch read, register file
// read and execute, and lw and lbu also read the data memory after the address add. The memory
// is four byte-wide banks with one registered read port, so a fetch and a data access share it
// one after the other; misaligned words are fine.
module mini_riscv_instruction_stepper #(
   parameter int MEM_BYTES = mrs_pkg::MEM_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  mrs_pkg::mrs_req_type req_item,
   output logic                rsp_strobe,
   output mrs_pkg::mrs_rsp_type rsp_item
);
   import mrs_pkg::*;

   localparam int ROWS  = (MEM_BYTES + 3) / 4;
   localparam int ROW_W = $clog2(ROWS);
   localparam int OFF_W = ROW_W + 2;

   // byte range check against the memory window
   function automatic logic in_mem(input logic [31:0] addr, input logic word);
      logic [31:0] span;
      span = {1'b0, addr[30:0]} + (word ? 32'd4 : 32'd1);
      return addr[31] && (span <= 32'(MEM_BYTES));
   endfunction

   // row within a bank for the byte of an access that lands in that bank
   function automatic logic [ROW_W-1:0] lane_row(input logic [OFF_W-1:0] off,
                                                  input logic [1:0] lane);
      logic [1:0]       k;
      logic [OFF_W-1:0] s;
      k = lane - off[1:0];
      s = off + OFF_W'(k);
      return s[OFF_W-1:2];
   endfunction

   // byte of a word that goes to a given bank
   function automatic logic [7:0] lane_byte(input logic [31:0] word,
                                            input logic [OFF_W-1:0] off,
                                            input logic [1:0] lane);
      logic [1:0]  k;
      logic [31:0] sh;
      k  = lane - off[1:0];
      sh = word >> {k, 3'b000};
      return sh[7:0];
   endfunction

   // State registers
   mrs_state_type    state_ff, state_in;
   logic [31:0]      pc_ff, pc_in;
   logic [31:0]      last_inst_ff, last_inst_in;
   logic             halt_ff, halt_in;
   logic [ROW_W-1:0] clr_row_ff, clr_row_in;
   mrs_rsp_type      rsp_ff, rsp_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   logic             ld_word_ff, ld_word_in;
   logic [4:0]       ld_rd_ff, ld_rd_in;

   // Memory read side
   logic [31:0]      raddr;
   logic             rword;
   logic             rd_ok_ff;
   logic [1:0]       rd_sh_ff;
   logic [7:0]       bank_q_ff [4];
   logic [31:0]      mem_word;

   // Memory write side
   logic [31:0]      waddr;
   logic [31:0]      wdata;
   logic             wword;
   logic             wen;
   logic             bank_wen  [4];
   logic [ROW_W-1:0] bank_wrow [4];
   logic [7:0]       bank_wdat [4];
   logic [ROW_W-1:0] bank_rrow [4];

   // Register file
   logic [31:0]      rf_mem [32];
   logic [31:0]      rf_vld_ff;
   logic [4:0]       rf_ra, rf_rb;
   logic [31:0]      rf_a_ff, rf_b_ff;
   logic             rf_a_vld_ff, rf_b_vld_ff;
   logic             rf_we;
   logic [4:0]       rf_wa;
   logic [31:0]      rf_wd;

   // Decode of the current instruction
   logic [31:0]      ins;
   logic [6:0]       opc;
   logic [4:0]       rd;
   logic [2:0]       f3;
   logic [6:0]       f7;
   logic [31:0]      src_a, src_b;
   logic [31:0]      imm_i, imm_s, imm_b;
   logic [31:0]      ea;
   logic [31:0]      pc_plus4;
   logic             accept;

   assign accept   = start && (state_ff == ST_IDLE);
   assign busy     = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   assign ins   = last_inst_ff;
   assign opc   = ins[6:0];
   assign rd    = ins[11:7];
   assign f3    = ins[14:12];
   assign f7    = ins[31:25];
   assign imm_i = {{20{ins[31]}}, ins[31:20]};
   assign imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
   assign imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
   assign src_a = rf_a_vld_ff ? rf_a_ff : 32'd0;
   assign src_b = rf_b_vld_ff ? rf_b_ff : 32'd0;
   assign ea    = src_a + ((opc == OPC_STORE) ? imm_s : imm_i);
   assign pc_plus4 = pc_ff + 32'd4;

   // reassemble the read word from the banks, zero when out of range
   always_comb begin
      mem_word = 32'd0;
      for (int k = 0; k < 4; k++) begin
         mem_word[8*k +: 8] = bank_q_ff[2'(rd_sh_ff + 2'(k))];
      end
      if (!rd_ok_ff) begin
         mem_word = 32'd0;
      end
   end

   // Sequencer: next state, memory and register file requests, result beat
   always_comb begin
      state_in      = state_ff;
      pc_in         = pc_ff;
      last_inst_in  = last_inst_ff;
      halt_in       = halt_ff;
      clr_row_in    = clr_row_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      ld_word_in    = ld_word_ff;
      ld_rd_in      = ld_rd_ff;

      raddr = pc_ff;
      rword = 1'b1;
      waddr = req_item.mem_addr;
      wdata = req_item.mem_data;
      wword = 1'b1;
      wen   = 1'b0;

      rf_ra = req_item.reg_index;
      rf_rb = 5'd0;
      rf_we = 1'b0;
      rf_wa = rd;
      rf_wd = 32'd0;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_row_in = clr_row_ff + ROW_W'(1);
            if (clr_row_ff == ROW_W'(ROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_item.op == OP_STEP) begin
                  state_in = ST_DECODE;
               end else if (req_item.op == OP_READ) begin
                  state_in = ST_READ;
               end else begin
                  wen = (req_item.op == OP_LOAD) && in_mem(req_item.mem_addr, 1'b1);
                  rsp_in        = '{next_pc: pc_ff, executed_inst: last_inst_ff,
                                    halt_flag: halt_ff, reg_value: 32'd0};
                  rsp_strobe_in = 1'b1;
               end
            end
         end
         ST_DECODE: begin
            last_inst_in = mem_word;
            rf_ra        = mem_word[19:15];
            rf_rb        = mem_word[24:20];
            state_in     = ST_EXEC;
         end
         ST_EXEC: begin
            pc_in = pc_plus4;
            raddr = ea;
            rword = (f3 != F3_BYTE_U);
            waddr = ea;
            wdata = src_b;
            wword = (f3 == F3_WORD);
            state_in = ST_IDLE;
            unique case (opc)
               OPC_OP: begin
                  rf_we = 1'b1;
                  rf_wd = (f3 == F3_ZERO && f7 == F7_ZERO) ? src_a + src_b : 32'd0;
               end
               OPC_LUI: begin
                  rf_we = 1'b1;
                  rf_wd = {ins[31:12], 12'd0};
               end
               OPC_OP_IMM: begin
                  rf_we = 1'b1;
                  rf_wd = (f3 == F3_ZERO) ? src_a + imm_i : 32'd0;
               end
               OPC_LOAD: begin
                  if (f3 == F3_WORD || f3 == F3_BYTE_U) begin
                     ld_word_in = (f3 == F3_WORD);
                     ld_rd_in   = rd;
                     state_in   = ST_LOAD_WB;
                  end else begin
                     rf_we = 1'b1;
                  end
               end
               OPC_STORE: begin
                  wen = (f3 == F3_ZERO || f3 == F3_WORD) && in_mem(ea, wword);
               end
               OPC_JALR: begin
                  if (f3 == F3_ZERO) begin
                     rf_we = 1'b1;
                     rf_wd = pc_plus4;
                     pc_in = (src_a + imm_i) & ~32'd1;
                  end
               end
               OPC_BRANCH: begin
                  if (f3 == F3_ZERO && src_a == src_b) begin
                     pc_in = pc_ff + imm_b;
                  end
               end
               OPC_SYSTEM: begin
                  if (f3 == F3_ZERO && ins[31:20] == IMM_EBREAK) begin
                     halt_in = 1'b1;
                  end
               end
               default: begin
               end
            endcase
            if (state_in == ST_IDLE) begin
               rsp_in        = '{next_pc: pc_in, executed_inst: last_inst_ff,
                                 halt_flag: halt_in, reg_value: 32'd0};
               rsp_strobe_in = 1'b1;
            end
         end
         ST_LOAD_WB: begin
            rf_we = 1'b1;
            rf_wa = ld_rd_ff;
            rf_wd = ld_word_ff ? mem_word : {24'd0, mem_word[7:0]};
            rsp_in        = '{next_pc: pc_ff, executed_inst: last_inst_ff,
                              halt_flag: halt_ff, reg_value: 32'd0};
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_READ: begin
            rsp_in        = '{next_pc: pc_ff, executed_inst: last_inst_ff,
                              halt_flag: halt_ff, reg_value: src_a};
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // x0 is never written
      if (rf_wa == 5'd0) begin
         rf_we = 1'b0;
      end
   end

   // per-bank write steering and read rows
   always_comb begin
      for (int b = 0; b < 4; b++) begin
         bank_rrow[b] = lane_row(raddr[OFF_W-1:0], 2'(b));
         if (state_ff == ST_CLEAR) begin
            bank_wen[b]  = 1'b1;
            bank_wrow[b] = clr_row_ff;
            bank_wdat[b] = 8'd0;
         end else begin
            bank_wen[b]  = wen && (wword || waddr[1:0] == 2'(b));
            bank_wrow[b] = lane_row(waddr[OFF_W-1:0], 2'(b));
            bank_wdat[b] = lane_byte(wdata, waddr[OFF_W-1:0], 2'(b));
         end
      end
   end

   // Byte memory: four banks, one write and one registered read each
   for (genvar g = 0; g < 4; g++) begin : g_bank
      logic [7:0] bank_mem [ROWS];

      always_ff @(posedge clock) begin
         if (bank_wen[g]) begin
            bank_mem[bank_wrow[g]] <= bank_wdat[g];
         end
         bank_q_ff[g] <= bank_mem[bank_rrow[g]];
      end
   end

   // read-side range flag and byte rotation travel with the read data
   always_ff @(posedge clock) begin
      rd_ok_ff <= in_mem(raddr, rword);
      rd_sh_ff <= raddr[1:0];
   end

   // Register file: two registered reads, one write
   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_mem[rf_wa] <= rf_wd;
      end
      rf_a_ff <= rf_mem[rf_ra];
      rf_b_ff <= rf_mem[rf_rb];
   end

   // register file valid bits; an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         rf_vld_ff   <= 32'd0;
         rf_a_vld_ff <= 1'b0;
         rf_b_vld_ff <= 1'b0;
      end else begin
         if (rf_we) begin
            rf_vld_ff[rf_wa] <= 1'b1;
         end
         rf_a_vld_ff <= rf_vld_ff[rf_ra];
         rf_b_vld_ff <= rf_vld_ff[rf_rb];
      end
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         pc_ff         <= MEM_BASE;
         last_inst_ff  <= 32'd0;
         halt_ff       <= 1'b0;
         clr_row_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pc_ff         <= pc_in;
         last_inst_ff  <= last_inst_in;
         halt_ff       <= halt_in;
         clr_row_ff    <= clr_row_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // result beat and load bookkeeping payload
   always_ff @(posedge clock) begin
      rsp_ff     <= rsp_in;
      ld_word_ff <= ld_word_in;
      ld_rd_ff   <= ld_rd_in;
   end

endmodule
